@@ hw/rtl/multilevel_priority_event_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Multilevel priority event queue - assertion macros
// Shared concurrent assertion shorthands, clocked with reset disable.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_EVENT_QUEUE_UNIT_DEFINES_SVH
`define MULTILEVEL_PRIORITY_EVENT_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define MPEQ_ASSERT_IMPL(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define MPEQ_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/mpeq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority event queue - package
// Field widths, operation and status codes, controller states and the
// per-level command bundle.
// ----------------------------------------------------------------------------
package mpeq_pkg;

    localparam int TIME_W   = 32;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 3;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SERVE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_FULL     = 3'd1,
        STATUS_SERVED   = 3'd2,
        STATUS_EMPTY    = 3'd3,
        STATUS_BAD_PRIO = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic              ins;
        logic              srv;
        logic [TIME_W-1:0] time_val;
        logic [ID_W-1:0]   id_val;
    } level_cmd_t;

endpackage

@@ hw/rtl/multilevel_priority_event_queue_unit.sv @@
`timescale 1ns / 1ps
// An input transaction is captured in the input register; the update of the chosen level and
// the result register follow together. No new transaction is accepted until that update is done;
// in it the cells of the chosen level shift, load or hold in parallel.
// A result waiting on m_ready stalls the update cycle, not input acceptance.
// Reset clears the level counts and the controller; slot contents stay undefined,
// there is no clearing pass.
// ----------------------------------------------------------------------------
// Multilevel priority event queue - top level
// Controller, level select and result register around a row of sorted levels.
// ----------------------------------------------------------------------------
`include "multilevel_priority_event_queue_unit_defines.svh"

module multilevel_priority_event_queue_unit #(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [mpeq_pkg::ID_W-1:0]     s_event_id,
    input  logic [mpeq_pkg::PRIO_W-1:0]   s_priority_req,
    input  logic [mpeq_pkg::TIME_W-1:0]   s_activation_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mpeq_pkg::STATUS_W-1:0] m_status,
    output logic [mpeq_pkg::ID_W-1:0]     m_served_id,
    output logic [mpeq_pkg::PRIO_W-1:0]   m_served_priority,
    output logic [mpeq_pkg::TIME_W-1:0]   m_served_time
);
    import mpeq_pkg::*;

    localparam int LVL_W = $clog2(LEVELS);

    state_t state_reg, state_next;

    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TIME_W-1:0] time_reg;

    logic              m_valid_reg, m_valid_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   sid_reg, sid_next;
    logic [PRIO_W-1:0] sprio_reg, sprio_next;
    logic [TIME_W-1:0] stime_reg, stime_next;

    level_cmd_t        cmd       [LEVELS];
    logic              lvl_full  [LEVELS];
    logic              lvl_nz    [LEVELS];
    logic [TIME_W-1:0] head_time [LEVELS];
    logic [ID_W-1:0]   head_id   [LEVELS];

    logic              out_free, fire, prio_ok, any_nz;
    logic [PRIO_W-1:0] prio_m1;
    logic [LVL_W-1:0]  ins_lvl, srv_lvl;
    logic [PRIO_W:0]   srv_prio;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == ST_EXEC) && out_free;

    assign prio_m1 = prio_reg - PRIO_W'(1);
    assign ins_lvl = prio_m1[LVL_W-1:0];
    assign prio_ok = (prio_reg != '0) && ({1'b0, prio_reg} <= (PRIO_W+1)'(LEVELS));

    always_comb begin
        srv_lvl = '0;
        any_nz  = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (lvl_nz[l]) begin
                srv_lvl = LVL_W'(l);
                any_nz  = 1'b1;
            end
        end
    end

    assign srv_prio = (PRIO_W+1)'(srv_lvl) + (PRIO_W+1)'(1);

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_level
            assign cmd[g].ins = fire && (op_reg == OP_INSERT) && prio_ok
                                && (ins_lvl == LVL_W'(g)) && !lvl_full[g];
            assign cmd[g].srv = fire && (op_reg == OP_SERVE) && any_nz
                                && (srv_lvl == LVL_W'(g));
            assign cmd[g].time_val = time_reg;
            assign cmd[g].id_val   = id_reg;

            mpeq_level #(
                .LEVEL_DEPTH (LEVEL_DEPTH)
            ) u_level (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd_i       (cmd[g]),
                .full_o      (lvl_full[g]),
                .nonempty_o  (lvl_nz[g]),
                .head_time_o (head_time[g]),
                .head_id_o   (head_id[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_operation);
            id_reg   <= s_event_id;
            prio_reg <= s_priority_req;
            time_reg <= s_activation_time;
        end
        status_reg <= status_next;
        sid_reg    <= sid_next;
        sprio_reg  <= sprio_next;
        stime_reg  <= stime_next;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        sid_next     = sid_reg;
        sprio_next   = sprio_reg;
        stime_next   = stime_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    sid_next     = '0;
                    sprio_next   = '0;
                    stime_next   = '0;
                    if (op_reg == OP_INSERT) begin
                        if (!prio_ok) begin
                            status_next = STATUS_BAD_PRIO;
                        end else if (lvl_full[ins_lvl]) begin
                            status_next = STATUS_FULL;
                        end else begin
                            status_next = STATUS_INSERTED;
                        end
                    end else if (any_nz) begin
                        status_next = STATUS_SERVED;
                        sid_next    = head_id[srv_lvl];
                        sprio_next  = srv_prio[PRIO_W-1:0];
                        stime_next  = head_time[srv_lvl];
                    end else begin
                        status_next = STATUS_EMPTY;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_served_id       = sid_reg;
    assign m_served_priority = sprio_reg;
    assign m_served_time     = stime_reg;

    `MPEQ_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, (state_reg == ST_EXEC) && !s_ready, "no update after accept")
    `MPEQ_ASSERT_NEXT(a_fire_result, aclk, aresetn, fire, m_valid_reg, "update produced no result")
    `MPEQ_ASSERT_IMPL(a_zero_fields, aclk, aresetn, m_valid_reg && (status_reg != STATUS_SERVED), (sid_reg == '0) && (sprio_reg == '0) && (stime_reg == '0), "non-serve result carries data")

endmodule

@@ hw/rtl/mpeq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority event queue - storage cell
// One slot of a level: compares its time with the new event and takes the
// new event, its left neighbour or its right neighbour.
// ----------------------------------------------------------------------------
module mpeq_cell (
    input  logic                       aclk,
    input  mpeq_pkg::level_cmd_t       cmd_i,
    input  logic                       occ_i,
    input  logic                       at_count_i,
    input  logic                       prev_ge_i,
    input  logic [mpeq_pkg::TIME_W-1:0] left_time_i,
    input  logic [mpeq_pkg::ID_W-1:0]   left_id_i,
    input  logic [mpeq_pkg::TIME_W-1:0] right_time_i,
    input  logic [mpeq_pkg::ID_W-1:0]   right_id_i,
    output logic                       ge_o,
    output logic [mpeq_pkg::TIME_W-1:0] time_o,
    output logic [mpeq_pkg::ID_W-1:0]   id_o
);
    import mpeq_pkg::*;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [ID_W-1:0]   id_reg, id_next;

    assign ge_o = occ_i && (time_reg >= cmd_i.time_val);

    always_comb begin
        time_next = time_reg;
        id_next   = id_reg;
        if (cmd_i.ins) begin
            if (prev_ge_i) begin
                time_next = left_time_i;
                id_next   = left_id_i;
            end else if (ge_o || at_count_i) begin
                time_next = cmd_i.time_val;
                id_next   = cmd_i.id_val;
            end
        end else if (cmd_i.srv) begin
            time_next = right_time_i;
            id_next   = right_id_i;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign time_o = time_reg;
    assign id_o   = id_reg;

endmodule

@@ hw/rtl/mpeq_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority event queue - priority level
// A chain of cells kept in time order with its fill count; insert shifts the
// tail right, serve shifts the whole chain left.
// ----------------------------------------------------------------------------
`include "multilevel_priority_event_queue_unit_defines.svh"

module mpeq_level #(
    parameter int LEVEL_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mpeq_pkg::level_cmd_t        cmd_i,
    output logic                        full_o,
    output logic                        nonempty_o,
    output logic [mpeq_pkg::TIME_W-1:0] head_time_o,
    output logic [mpeq_pkg::ID_W-1:0]   head_id_o
);
    import mpeq_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] cell_time [LEVEL_DEPTH];
    logic [ID_W-1:0]   cell_id   [LEVEL_DEPTH];
    logic              cell_ge   [LEVEL_DEPTH];

    genvar j;
    generate
        for (j = 0; j < LEVEL_DEPTH; j++) begin : g_cell
            logic              prev_ge;
            logic [TIME_W-1:0] left_time, right_time;
            logic [ID_W-1:0]   left_id, right_id;

            if (j == 0) begin : g_first
                assign prev_ge   = 1'b0;
                assign left_time = cmd_i.time_val;
                assign left_id   = cmd_i.id_val;
            end else begin : g_mid
                assign prev_ge   = cell_ge[j-1];
                assign left_time = cell_time[j-1];
                assign left_id   = cell_id[j-1];
            end

            if (j == LEVEL_DEPTH - 1) begin : g_last
                assign right_time = cell_time[j];
                assign right_id   = cell_id[j];
            end else begin : g_inner
                assign right_time = cell_time[j+1];
                assign right_id   = cell_id[j+1];
            end

            mpeq_cell u_cell (
                .aclk         (aclk),
                .cmd_i        (cmd_i),
                .occ_i        (CNT_W'(j) < count_reg),
                .at_count_i   (CNT_W'(j) == count_reg),
                .prev_ge_i    (prev_ge),
                .left_time_i  (left_time),
                .left_id_i    (left_id),
                .right_time_i (right_time),
                .right_id_i   (right_id),
                .ge_o         (cell_ge[j]),
                .time_o       (cell_time[j]),
                .id_o         (cell_id[j])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd_i.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd_i.srv) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign full_o      = (count_reg == CNT_W'(LEVEL_DEPTH));
    assign nonempty_o  = (count_reg != '0);
    assign head_time_o = cell_time[0];
    assign head_id_o   = cell_id[0];

    `MPEQ_ASSERT_IMPL(a_ins_not_full, aclk, aresetn, cmd_i.ins, !full_o, "insert into full level")
    `MPEQ_ASSERT_IMPL(a_srv_not_empty, aclk, aresetn, cmd_i.srv, nonempty_o, "serve of empty level")
    `MPEQ_ASSERT_NEXT(a_ins_count, aclk, aresetn, cmd_i.ins, count_reg == CNT_W'($past(count_reg) + CNT_W'(1)), "count not advanced")

endmodule
